### hdl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared constants, codes and controller/datapath interface types of the
// open addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

	// table geometry
	localparam int TABLE_SLOTS = 1021;
	localparam int STEP_PRIME  = 1019;

	// field widths
	localparam int KEY_W      = 31;
	localparam int FUNC_W     = 2;
	localparam int STATUS_W   = 3;
	localparam int OUT_SLOT_W = 10;
	localparam int MODE_W     = 2;
	localparam int SLOT_ST_W  = 2;
	localparam int ENTRY_W    = KEY_W + SLOT_ST_W;

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int STEP_W = $clog2(STEP_PRIME);

	// reciprocals for key mod table size and key mod step prime
	localparam int RCP_W = KEY_W + 1;
	localparam int RSH_T = KEY_W + SLOT_W;
	localparam int RSH_P = KEY_W + STEP_W;
	localparam logic [RCP_W-1:0] RCP_T = RCP_W'((64'd1 << RSH_T) / 64'(TABLE_SLOTS));
	localparam logic [RCP_W-1:0] RCP_P = RCP_W'((64'd1 << RSH_P) / 64'(STEP_PRIME));

	// operation codes
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

	// insert probe modes
	localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

	// slot status codes
	localparam logic [SLOT_ST_W-1:0] SLOT_EMPTY = 2'd0;
	localparam logic [SLOT_ST_W-1:0] SLOT_USED  = 2'd1;
	localparam logic [SLOT_ST_W-1:0] SLOT_TOMB  = 2'd2;

	// result codes
	localparam logic [STATUS_W-1:0] RES_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] RES_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] RES_HIT      = 3'd2;
	localparam logic [STATUS_W-1:0] RES_MISS     = 3'd3;
	localparam logic [STATUS_W-1:0] RES_DELETED  = 3'd4;
	localparam logic [STATUS_W-1:0] RES_DEL_MISS = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic                  load_key;
		logic                  init;
		logic                  ins;
		logic                  advance;
		logic                  rd_next;
		logic                  clr_inc;
		logic                  wr_en;
		logic [SLOT_ST_W-1:0]  wr_stat;
		logic                  load_res;
		logic [STATUS_W-1:0]   res_code;
		logic                  res_hit;
	} oaht_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic used;
		logic empty;
		logic match;
		logic clr_last;
	} oaht_sts_t;

endpackage

### hdl/oaht_ram.sv
// ----------------------------------------------------------------------------
// oaht_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### hdl/oaht_dp.sv
// ----------------------------------------------------------------------------
// oaht_dp
// Datapath: key hashing, probe address stepping, slot store and result
// register.
// ----------------------------------------------------------------------------
module oaht_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [oaht_pkg::MODE_W-1:0]     cfg_mode,
	input  logic [oaht_pkg::KEY_W-1:0]      key_in,
	input  oaht_pkg::oaht_cmd_t             cmd,
	output oaht_pkg::oaht_sts_t             sts,
	output logic [oaht_pkg::STATUS_W-1:0]   res_status,
	output logic [oaht_pkg::OUT_SLOT_W-1:0] res_slot
);
	import oaht_pkg::*;

	logic [MODE_W-1:0]       mode_q;
	logic [KEY_W-1:0]        key_q;
	logic [KEY_W+RCP_W-1:0]  prod_t_s1;
	logic [KEY_W+RCP_W-1:0]  prod_p_s1;
	logic [SLOT_W:0]         rem_t_s2;
	logic [STEP_W:0]         rem_p_s2;
	logic [SLOT_W-1:0]       idx_q;
	logic [SLOT_W-1:0]       step_q;
	logic                    quad_q;
	logic [STATUS_W-1:0]     res_status_q;
	logic [OUT_SLOT_W-1:0]   res_slot_q;

	logic [KEY_W-1:0]        quot_t, quot_p, mul_t, mul_p, diff_t, diff_p;
	logic [SLOT_W-1:0]       home;
	logic [STEP_W-1:0]       rem_p, step2;
	logic [SLOT_W:0]         idx_sum, step_sum;
	logic [SLOT_W-1:0]       idx_next, step_next;
	logic [SLOT_W-1:0]       ram_addr;
	logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
	logic [SLOT_ST_W-1:0]    rd_stat;

	// reciprocal quotients, at most one short of the true quotient
	assign quot_t = KEY_W'(prod_t_s1 >> RSH_T);
	assign quot_p = KEY_W'(prod_p_s1 >> RSH_P);
	assign mul_t  = quot_t * KEY_W'(TABLE_SLOTS);
	assign mul_p  = quot_p * KEY_W'(STEP_PRIME);
	assign diff_t = key_q - mul_t;
	assign diff_p = key_q - mul_p;

	// one correction step
	assign home  = (rem_t_s2 >= (SLOT_W+1)'(TABLE_SLOTS)) ?
		SLOT_W'(rem_t_s2 - (SLOT_W+1)'(TABLE_SLOTS)) : rem_t_s2[SLOT_W-1:0];
	assign rem_p = (rem_p_s2 >= (STEP_W+1)'(STEP_PRIME)) ?
		STEP_W'(rem_p_s2 - (STEP_W+1)'(STEP_PRIME)) : rem_p_s2[STEP_W-1:0];
	assign step2 = STEP_W'(STEP_PRIME) - rem_p;

	// next probe slot and next quadratic increment, both mod table size
	assign idx_sum   = {1'b0, idx_q} + {1'b0, step_q};
	assign idx_next  = (idx_sum >= (SLOT_W+1)'(TABLE_SLOTS)) ?
		SLOT_W'(idx_sum - (SLOT_W+1)'(TABLE_SLOTS)) : idx_sum[SLOT_W-1:0];
	assign step_sum  = {1'b0, step_q} + (SLOT_W+1)'(2);
	assign step_next = (step_sum >= (SLOT_W+1)'(TABLE_SLOTS)) ?
		SLOT_W'(step_sum - (SLOT_W+1)'(TABLE_SLOTS)) : step_sum[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		prod_t_s1 <= key_q * RCP_T;
		prod_p_s1 <= key_q * RCP_P;
		rem_t_s2  <= diff_t[SLOT_W:0];
		rem_p_s2  <= diff_p[STEP_W:0];
		if (cmd.load_key) begin
			key_q <= key_in;
		end
		if (cmd.load_res) begin
			res_status_q <= cmd.res_code;
			res_slot_q   <= cmd.res_hit ? OUT_SLOT_W'(idx_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LINEAR;
			idx_q  <= '0;
			step_q <= SLOT_W'(1);
			quad_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_mode;
			end
			if (cmd.clr_inc) begin
				// wrap back to slot zero once the last slot is cleared
				idx_q <= (idx_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : SLOT_W'(idx_q + 1'b1);
			end else if (cmd.init) begin
				idx_q  <= home;
				step_q <= (cmd.ins && mode_q == MODE_DOUBLE) ? SLOT_W'(step2) : SLOT_W'(1);
				quad_q <= cmd.ins && mode_q == MODE_QUAD;
			end else if (cmd.advance) begin
				idx_q <= idx_next;
				if (quad_q) begin
					step_q <= step_next;
				end
			end
		end
	end

	assign ram_addr  = cmd.rd_next ? idx_next : idx_q;
	assign ram_wdata = {cmd.wr_stat, key_q};

	oaht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (cmd.wr_en),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign rd_stat      = ram_rdata[ENTRY_W-1:KEY_W];
	assign sts.used     = rd_stat == SLOT_USED;
	assign sts.empty    = rd_stat == SLOT_EMPTY;
	assign sts.match    = ram_rdata[KEY_W-1:0] == key_q;
	assign sts.clr_last = idx_q == SLOT_W'(TABLE_SLOTS - 1);

	assign res_status = res_status_q;
	assign res_slot   = res_slot_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < SLOT_W'(TABLE_SLOTS))
		else $error("probe slot out of table");
	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init |=> (step_q != '0 && step_q < SLOT_W'(TABLE_SLOTS)))
		else $error("probe step zero or out of range");

endmodule

### hdl/oaht_ctrl.sv
// ----------------------------------------------------------------------------
// oaht_ctrl
// Controller: clearing pass, request sequencing, probe loop decisions and
// output handshake.
// ----------------------------------------------------------------------------
module oaht_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_valid,
	output logic                        s_ready,
	input  logic [oaht_pkg::FUNC_W-1:0] func_in,
	output logic                        m_valid,
	input  logic                        m_ready,
	input  oaht_pkg::oaht_sts_t         sts,
	output oaht_pkg::oaht_cmd_t         cmd
);
	import oaht_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH1,
		S_HASH2,
		S_INIT,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	state_t              state_q, state_d;
	logic [FUNC_W-1:0]   func_q;
	logic [SLOT_W-1:0]   cnt_q;
	logic [STATUS_W-1:0] code_q, code_d;
	logic                hit_q, hit_d;
	logic                out_valid_q;
	logic                fin;
	logic                ins, del, last;

	assign ins  = func_q == FN_INSERT;
	assign del  = func_q == FN_DELETE;
	assign last = cnt_q == SLOT_W'(TABLE_SLOTS - 1);

	assign s_ready = state_q == S_IDLE;
	assign m_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.ins = ins;
		cmd.res_code = code_q;
		cmd.res_hit  = hit_q;
		fin    = 1'b0;
		code_d = code_q;
		hit_d  = hit_q;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_stat = SLOT_EMPTY;
				cmd.clr_inc = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.load_key = s_valid;
				if (s_valid) begin
					state_d = S_HASH1;
				end
			end
			S_HASH1: state_d = S_HASH2;
			S_HASH2: state_d = S_INIT;
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = S_READ;
			end
			S_READ: state_d = S_CHECK;
			S_CHECK: begin
				if (ins) begin
					if (!sts.used) begin
						cmd.wr_en   = 1'b1;
						cmd.wr_stat = SLOT_USED;
						fin    = 1'b1;
						code_d = RES_INSERTED;
						hit_d  = 1'b1;
					end else if (last) begin
						fin    = 1'b1;
						code_d = RES_FULL;
						hit_d  = 1'b0;
					end
				end else begin
					if (sts.used && sts.match) begin
						cmd.wr_en   = del;
						cmd.wr_stat = SLOT_TOMB;
						fin    = 1'b1;
						code_d = del ? RES_DELETED : RES_HIT;
						hit_d  = 1'b1;
					end else if (sts.empty || last) begin
						fin    = 1'b1;
						code_d = del ? RES_DEL_MISS : RES_MISS;
						hit_d  = 1'b0;
					end
				end
				if (fin) begin
					state_d = S_DONE;
				end else begin
					cmd.advance = 1'b1;
					cmd.rd_next = 1'b1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_ready) begin
					cmd.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			func_q      <= FN_INSERT;
			cnt_q       <= '0;
			code_q      <= RES_INSERTED;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			hit_q   <= hit_d;
			if (s_valid && s_ready) begin
				func_q <= func_in;
			end
			if (cmd.init) begin
				cnt_q <= '0;
			end else if (cmd.advance) begin
				cnt_q <= SLOT_W'(cnt_q + 1'b1);
			end
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_starts_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready) |=> state_q == S_HASH1)
		else $error("accepted request did not start hashing");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |-> state_q == S_DONE)
		else $error("result loaded outside done state");
	a_no_load_over_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_ready) |=> !$past(cmd.load_res))
		else $error("pending result overwritten");
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (state_q == S_CLEAR || state_q == S_CHECK))
		else $error("slot store written outside clear or probe");

endmodule

### hdl/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Fixed-size hash table with open addressing and tombstones. Insert probes
// linear, quadratic or double hashing; search and delete probe linearly.
//
//   channel   direction  handshake                   payload
//   s_axis    in         s_axis_tvalid/tready        tdata key, tuser func
//   m_axis    out        m_axis_tvalid/tready        tdata slot_index, tuser status
//   cfg       in         cfg_valid/cfg_ready         cfg_data probe_mode
//
// a request is hashed through two reciprocal multipliers, then probes 1 to
// TABLE_SLOTS slots, each probe one read of the single-port slot RAM; the
// next request is taken only after the result is loaded.
// after reset a clearing pass writes every slot empty, one per cycle, so
// s_axis_tready stays low until the pass is through; cfg is always open.
// a finished result waits in the output register while the next request
// is taken and hashed; m_axis_tready low stalls only the final load.
// ----------------------------------------------------------------------------
module open_addressing_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	// request in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [30:0] key, [31] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] func
	// result out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [9:0] slot_index, [15:10] zero
	output logic [2:0]  m_axis_tuser,   // [2:0] status
	// probe mode register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);
	import oaht_pkg::*;

	oaht_cmd_t             cmd;
	oaht_sts_t             sts;
	logic [STATUS_W-1:0]   res_status;
	logic [OUT_SLOT_W-1:0] res_slot;

	// the register takes all writes; the user must see it is written only while idle
	assign cfg_ready = 1'b1;

	// sequencing and handshakes
	oaht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.s_valid(s_axis_tvalid),
		.s_ready(s_axis_tready),
		.func_in(s_axis_tuser),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.sts    (sts),
		.cmd    (cmd)
	);

	// hashing, probing, slot store and result register
	oaht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_mode  (cfg_data),
		.key_in    (s_axis_tdata[KEY_W-1:0]),
		.cmd       (cmd),
		.sts       (sts),
		.res_status(res_status),
		.res_slot  (res_slot)
	);

	// pad slot index up to whole bytes
	assign m_axis_tdata = {{(16 - OUT_SLOT_W){1'b0}}, res_slot};
	assign m_axis_tuser = res_status;

endmodule
